/* src/terq_pkg.sv */
// shared types and constants for the timed event release queue
package terq_pkg;

    localparam int MaxTriggers = 32;
    localparam int MaxUnits    = 16;
    localparam int PayloadBits = 32;
    localparam int TimeW       = 48;
    localparam int TrigIdxW    = $clog2(MaxTriggers);
    localparam int TrigCntW    = $clog2(MaxTriggers + 1);
    localparam int UnitIdxW    = $clog2(MaxUnits);
    localparam int UnitCntW    = $clog2(MaxUnits + 1);
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
    localparam logic [15:0] TickReset = 16'd4267;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_UNIT    = 2'd1;
    localparam logic [1:0] OP_TRIGGER = 2'd2;
    localparam logic [1:0] OP_ADVANCE = 2'd3;

    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    localparam logic [1:0] REG_TICK  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic do_clear;
        logic do_fail;
        logic do_unit;
        logic do_insert;
        logic do_advance;
        logic rel_step;
        logic out_load;
        logic [1:0] out_status;
        logic out_last;
        logic out_release;
    } terq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic load_fail;
        logic adv_ignore;
        logic rel_avail;
        logic rel_next;
    } terq_stat_t;

endpackage

/* src/terq_datapath.sv */
// queue storage, insertion chain, delay multiply and release readout
module terq_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  terq_pkg::terq_cmd_t           cmd,
    output terq_pkg::terq_stat_t          stat,
    input  logic [15:0]                   tick_per_frame,
    input  logic [terq_pkg::TimeW-1:0]    start_time,
    input  logic [1:0]                    op,
    input  logic [7:0]                    unit_kind_in,
    input  logic [15:0]                   sound_in,
    input  logic [31:0]                   delay_amount,
    input  logic                          delay_is_frames,
    input  logic                          delay_bad,
    input  logic [7:0]                    target_unit,
    input  logic [31:0]                   trigger_data,
    input  logic [terq_pkg::TimeW-1:0]    now_time,
    output logic [1:0]                    status,
    output logic [terq_pkg::TimeW-1:0]    due_time,
    output logic [4:0]                    load_index,
    output logic [7:0]                    unit_out,
    output logic [31:0]                   data_out,
    output logic                          unit_known,
    output logic [7:0]                    kind_out,
    output logic [15:0]                   sound_out,
    output logic                          last
);

    localparam int N = terq_pkg::MaxTriggers;
    localparam int M = terq_pkg::MaxUnits;

    // captured item
    logic [1:0]  op_reg;
    logic [7:0]  kind_in_reg;
    logic [15:0] sound_in_reg;
    logic [terq_pkg::TimeW-1:0] delay_reg;
    logic        frames_reg, bad_reg;
    logic [7:0]  tunit_reg;
    logic [31:0] tdata_reg;
    logic [terq_pkg::TimeW-1:0] now_reg;

    // trigger cells, kept sorted
    logic [terq_pkg::TimeW-1:0] due_reg [N];
    logic [4:0]                 ord_reg [N];
    logic [7:0]                 unit_reg [N];
    logic [terq_pkg::PayloadBits-1:0] pay_reg [N];
    logic [7:0]  kinds_reg [M];
    logic [15:0] sounds_reg [M];

    logic [terq_pkg::UnitCntW-1:0] unit_count_reg;
    logic [terq_pkg::TrigCntW-1:0] entry_count_reg;
    logic [terq_pkg::TrigCntW-1:0] rel_ptr_reg;
    logic [terq_pkg::TimeW-1:0]    last_sample_reg;
    logic releasing_reg, active_reg;

    logic [47:0] product;
    logic [terq_pkg::TimeW:0] due_sum;
    logic [terq_pkg::TimeW-1:0] due_new;
    logic [N-1:0] greater;
    logic [N-1:0] shift_in;
    logic [terq_pkg::TrigIdxW-1:0] rp;
    logic [terq_pkg::TrigIdxW-1:0] rp_next;
    logic [terq_pkg::UnitIdxW-1:0] ui;
    logic entries_full, units_full;

    assign product = 48'(delay_amount) * 48'(tick_per_frame);
    assign due_sum = {1'b0, start_time} + {1'b0, delay_reg};
    assign due_new = due_sum[terq_pkg::TimeW] ? terq_pkg::TimeMax
                                             : due_sum[terq_pkg::TimeW-1:0];
    assign entries_full = entry_count_reg >= terq_pkg::TrigCntW'(N);
    assign units_full   = unit_count_reg >= terq_pkg::UnitCntW'(M);
    assign rp = rel_ptr_reg[terq_pkg::TrigIdxW-1:0];
    assign rp_next = rp + 1'b1;
    assign ui = unit_reg[rp][terq_pkg::UnitIdxW-1:0];

    always_comb
    begin
        for (int i = 0; i < N; i++)
            greater[i] = (terq_pkg::TrigCntW'(i) < entry_count_reg) && (due_reg[i] > due_new);
    end

    // a cell takes its lower neighbor when that neighbor is later than the new trigger
    assign shift_in = {greater[N-2:0], 1'b0};

    assign stat.op = op_reg;
    assign stat.load_fail = releasing_reg ||
        ((op_reg == terq_pkg::OP_UNIT) && units_full) ||
        ((op_reg == terq_pkg::OP_TRIGGER) &&
         (bad_reg || entries_full || (frames_reg && (tick_per_frame == 16'd0))));
    assign stat.adv_ignore = !active_reg || (now_reg < last_sample_reg);
    assign stat.rel_avail = (rel_ptr_reg < entry_count_reg) && (due_reg[rp] <= now_reg);
    assign stat.rel_next = ((rel_ptr_reg + 1'b1) < entry_count_reg) &&
                           (due_reg[rp_next] <= now_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= op;
            kind_in_reg  <= unit_kind_in;
            sound_in_reg <= sound_in;
            delay_reg    <= delay_is_frames ? {8'd0, product[47:8]}
                                            : terq_pkg::TimeW'(delay_amount);
            frames_reg   <= delay_is_frames;
            bad_reg      <= delay_bad;
            tunit_reg    <= target_unit;
            tdata_reg    <= trigger_data;
            now_reg      <= now_time;
        end
        if (cmd.do_unit)
        begin
            kinds_reg[unit_count_reg[terq_pkg::UnitIdxW-1:0]]  <= kind_in_reg;
            sounds_reg[unit_count_reg[terq_pkg::UnitIdxW-1:0]] <= sound_in_reg;
        end
        // later cells move up one place, the new trigger lands in the gap
        if (cmd.do_insert)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (shift_in[i])
                begin
                    due_reg[i]  <= due_reg[(i > 0) ? i - 1 : 0];
                    ord_reg[i]  <= ord_reg[(i > 0) ? i - 1 : 0];
                    unit_reg[i] <= unit_reg[(i > 0) ? i - 1 : 0];
                    pay_reg[i]  <= pay_reg[(i > 0) ? i - 1 : 0];
                end
                else if (greater[i] || terq_pkg::TrigCntW'(i) == entry_count_reg)
                begin
                    due_reg[i]  <= due_new;
                    ord_reg[i]  <= entry_count_reg[4:0];
                    unit_reg[i] <= tunit_reg;
                    pay_reg[i]  <= terq_pkg::PayloadBits'(tdata_reg);
                end
            end
        end
        if (cmd.out_load)
        begin
            status <= cmd.out_status;
            last   <= cmd.out_last;
            if (cmd.out_release)
            begin
                due_time   <= due_reg[rp];
                load_index <= ord_reg[rp];
                unit_out   <= unit_reg[rp];
                data_out   <= 32'(pay_reg[rp]);
                unit_known <= ({1'b0, unit_reg[rp]} < 9'(unit_count_reg)) &&
                              (unit_reg[rp] < 8'(M));
                kind_out   <= (({1'b0, unit_reg[rp]} < 9'(unit_count_reg)) &&
                               (unit_reg[rp] < 8'(M))) ? kinds_reg[ui] : 8'd0;
                sound_out  <= (({1'b0, unit_reg[rp]} < 9'(unit_count_reg)) &&
                               (unit_reg[rp] < 8'(M))) ? sounds_reg[ui] : 16'd0;
            end
            else
            begin
                due_time   <= '0;
                load_index <= '0;
                unit_out   <= '0;
                data_out   <= '0;
                unit_known <= 1'b0;
                kind_out   <= '0;
                sound_out  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg  <= '0;
            entry_count_reg <= '0;
            rel_ptr_reg     <= '0;
            last_sample_reg <= '0;
            releasing_reg   <= 1'b0;
            active_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                unit_count_reg  <= '0;
                entry_count_reg <= '0;
                rel_ptr_reg     <= '0;
                releasing_reg   <= 1'b0;
                active_reg      <= 1'b1;
                last_sample_reg <= start_time;
            end
            if (cmd.do_fail)
            begin
                unit_count_reg  <= '0;
                entry_count_reg <= '0;
                rel_ptr_reg     <= '0;
                releasing_reg   <= 1'b0;
                active_reg      <= 1'b0;
                last_sample_reg <= '0;
            end
            if (cmd.do_unit)
                unit_count_reg <= unit_count_reg + 1'b1;
            if (cmd.do_insert)
                entry_count_reg <= entry_count_reg + 1'b1;
            if (cmd.do_advance)
            begin
                last_sample_reg <= now_reg;
                releasing_reg   <= 1'b1;
                if (rel_ptr_reg >= entry_count_reg)
                    active_reg <= 1'b0;
            end
            if (cmd.rel_step)
            begin
                rel_ptr_reg <= rel_ptr_reg + 1'b1;
                if (rel_ptr_reg + 1'b1 >= entry_count_reg)
                    active_reg <= 1'b0;
            end
        end
    end

endmodule

/* src/terq_ctrl.sv */
// sequencing of one item: decode, update, result handoff
module terq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  terq_pkg::terq_stat_t  stat,
    output terq_pkg::terq_cmd_t   cmd
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_REL} state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic [5:0] n_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        case (state_reg)
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_status = terq_pkg::ST_OK;
                    case (stat.op)
                        terq_pkg::OP_CLEAR:
                            cmd.do_clear = 1'b1;
                        terq_pkg::OP_UNIT, terq_pkg::OP_TRIGGER:
                        begin
                            if (stat.load_fail)
                            begin
                                cmd.do_fail = 1'b1;
                                cmd.out_status = terq_pkg::ST_ERROR;
                            end
                            else if (stat.op == terq_pkg::OP_UNIT)
                                cmd.do_unit = 1'b1;
                            else
                                cmd.do_insert = 1'b1;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b0;
                            if (stat.adv_ignore)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_status = terq_pkg::ST_IGNORED;
                            end
                            else
                                cmd.do_advance = 1'b1;
                        end
                    endcase
                end
            end
            S_REL:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.rel_avail && n_reg < 6'd32)
                    begin
                        cmd.out_release = 1'b1;
                        cmd.out_status = terq_pkg::ST_RELEASED;
                        cmd.rel_step = 1'b1;
                        // the next cell decides whether this transfer is the final one
                        cmd.out_last = !(stat.rel_next && n_reg < 6'd31);
                    end
                    else
                    begin
                        // first pass with nothing due gives a plain ok
                        cmd.out_status = terq_pkg::ST_OK;
                        cmd.out_last = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_EXEC;
                S_EXEC:
                    if (out_free)
                    begin
                        n_reg <= '0;
                        state_reg <= cmd.do_advance ? S_REL : S_IDLE;
                    end
                S_REL:
                    if (out_free)
                    begin
                        if (cmd.rel_step)
                        begin
                            n_reg <= n_reg + 1'b1;
                            state_reg <= cmd.out_last ? S_IDLE : S_REL;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/timed_event_release_queue.sv */
// top level of the timed event release queue
//
// one item is taken on the input channel when in_valid is high and in_stall low;
// op selects clear, unit load, trigger load or advance. each item gives one
// result transfer, an advance gives one transfer per released trigger (up to
// 32) with last set on the final one, or a single status transfer.
// a clear, a load or an ignored advance is handled in the exec state, which
// loads its result; the next item is taken once the block is back in idle.
// an advance that runs moves to the release state, which sends released triggers
// in order, or an ok status when nothing is due; the next cell is compared while
// the current one is sent, so the last flag is known with each released trigger.
// in_stall stays high from the input transfer until the final result is loaded.
// while the receiver stalls the output register holds and the block stops.
// reset empties both tables, leaves the queue inactive and sets the registers
// to tick 4267 and start time zero. configuration is written through the apb
// port by the user only while the block is idle; the block does not enforce it.
module timed_event_release_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  unit_kind_in,
    input  logic [15:0] sound_in,
    input  logic [31:0] delay_amount,
    input  logic        delay_is_frames,
    input  logic        delay_bad,
    input  logic [7:0]  target_unit,
    input  logic [31:0] trigger_data,
    input  logic [47:0] now_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [47:0] due_time,
    output logic [4:0]  load_index,
    output logic [7:0]  unit_out,
    output logic [31:0] data_out,
    output logic        unit_known,
    output logic [7:0]  kind_out,
    output logic [15:0] sound_out,
    output logic        last
);

    logic [15:0] tick_reg;
    logic [47:0] start_reg;
    terq_pkg::terq_cmd_t  cmd;
    terq_pkg::terq_stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= terq_pkg::TickReset;
            start_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[3:2] == 2'd0 && paddr[1:0] == 2'd0 && paddr[3] == 1'b0)
                tick_reg <= pwdata[15:0];
            else if (paddr == 4'd8)
                start_reg <= pwdata[47:0];
        end
    end

    always_comb
    begin
        case (paddr[3])
            terq_pkg::REG_TICK[0]:  prdata = {48'd0, tick_reg};
            terq_pkg::REG_START[0]: prdata = {16'd0, start_reg};
            default:                prdata = '0;
        endcase
    end

    terq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    terq_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .tick_per_frame  (tick_reg),
        .start_time      (start_reg),
        .op              (op),
        .unit_kind_in    (unit_kind_in),
        .sound_in        (sound_in),
        .delay_amount    (delay_amount),
        .delay_is_frames (delay_is_frames),
        .delay_bad       (delay_bad),
        .target_unit     (target_unit),
        .trigger_data    (trigger_data),
        .now_time        (now_time),
        .status          (status),
        .due_time        (due_time),
        .load_index      (load_index),
        .unit_out        (unit_out),
        .data_out        (data_out),
        .unit_known      (unit_known),
        .kind_out        (kind_out),
        .sound_out       (sound_out),
        .last            (last)
    );

endmodule

/* tb/tb_timed_event_release_queue.sv */
// self-checking testbench for the timed event release queue
`timescale 1ns / 1ps

module tb_timed_event_release_queue;

    localparam int LimitCycles = 600000;
    localparam int DrainCycles = 40;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  kind;
        logic [15:0] sound;
        logic [31:0] amount;
        logic        frames;
        logic        bad;
        logic [7:0]  unit;
        logic [31:0] data;
        logic [47:0] now;
    } item_t;

    typedef struct {
        logic [1:0]  status;
        logic [47:0] due;
        logic [4:0]  idx;
        logic [7:0]  unit;
        logic [31:0] data;
        logic        known;
        logic [7:0]  kind;
        logic [15:0] sound;
        logic        last;
    } result_t;

    class release_scoreboard;
        bit [47:0] due_tab[terq_pkg::MaxTriggers];
        bit [4:0]  order_tab[terq_pkg::MaxTriggers];
        bit [7:0]  unit_tab[terq_pkg::MaxTriggers];
        bit [31:0] data_tab[terq_pkg::MaxTriggers];
        bit [7:0]  kinds[terq_pkg::MaxUnits];
        bit [15:0] sounds[terq_pkg::MaxUnits];
        int        units;
        int        entries;
        int        rel_ptr;
        bit [47:0] last_now;
        bit        releasing;
        bit        armed;
        bit [15:0] tick;
        bit [47:0] start;
        result_t   release_q[$];

        function void power_up();
            units = 0;
            entries = 0;
            rel_ptr = 0;
            releasing = 0;
            armed = 0;
            last_now = '0;
            tick = terq_pkg::TickReset;
            start = '0;
            release_q.delete();
        endfunction

        function void push_status(logic [1:0] st);
            result_t r;
            r = '{default: '0};
            r.status = st;
            r.last = 1'b1;
            release_q.insert(release_q.size(), r);
        endfunction

        function void drop_all();
            units = 0;
            entries = 0;
            rel_ptr = 0;
            releasing = 0;
            armed = 0;
            last_now = '0;
            push_status(terq_pkg::ST_ERROR);
        endfunction

        function int pending();
            return release_q.size();
        endfunction

        function void note_input(item_t it);
            bit [47:0] prod;
            bit [47:0] delay;
            bit [48:0] sum;
            bit [47:0] due;
            int pos;
            int n;
            result_t r;
            case (it.op)
                terq_pkg::OP_CLEAR:
                begin
                    units = 0;
                    entries = 0;
                    rel_ptr = 0;
                    releasing = 0;
                    armed = 1;
                    last_now = start;
                    push_status(terq_pkg::ST_OK);
                end
                terq_pkg::OP_UNIT:
                begin
                    if (releasing || units >= terq_pkg::MaxUnits)
                        drop_all();
                    else
                    begin
                        kinds[units] = it.kind;
                        sounds[units] = it.sound;
                        units++;
                        push_status(terq_pkg::ST_OK);
                    end
                end
                terq_pkg::OP_TRIGGER:
                begin
                    if (releasing || it.bad || entries >= terq_pkg::MaxTriggers ||
                        (it.frames && tick == 0))
                        drop_all();
                    else
                    begin
                        prod = 48'(it.amount) * 48'(tick);
                        delay = it.frames ? (prod >> 8) : 48'(it.amount);
                        sum = 49'(start) + 49'(delay);
                        due = sum[48] ? terq_pkg::TimeMax : sum[47:0];
                        pos = entries;
                        while (pos > 0 && due_tab[pos-1] > due)
                            pos--;
                        for (int i = entries; i > pos; i--)
                        begin
                            due_tab[i] = due_tab[i-1];
                            order_tab[i] = order_tab[i-1];
                            unit_tab[i] = unit_tab[i-1];
                            data_tab[i] = data_tab[i-1];
                        end
                        due_tab[pos] = due;
                        order_tab[pos] = 5'(entries);
                        unit_tab[pos] = it.unit;
                        data_tab[pos] = it.data;
                        entries++;
                        push_status(terq_pkg::ST_OK);
                    end
                end
                default:
                begin
                    if (!armed || it.now < last_now)
                        push_status(terq_pkg::ST_IGNORED);
                    else
                    begin
                        last_now = it.now;
                        releasing = 1;
                        n = 0;
                        while (n < terq_pkg::MaxTriggers && rel_ptr < entries &&
                               due_tab[rel_ptr] <= it.now)
                        begin
                            r = '{default: '0};
                            r.status = terq_pkg::ST_RELEASED;
                            r.due = due_tab[rel_ptr];
                            r.idx = order_tab[rel_ptr];
                            r.unit = unit_tab[rel_ptr];
                            r.data = data_tab[rel_ptr];
                            if (unit_tab[rel_ptr] < units)
                            begin
                                r.known = 1'b1;
                                r.kind = kinds[unit_tab[rel_ptr]];
                                r.sound = sounds[unit_tab[rel_ptr]];
                            end
                            release_q.insert(release_q.size(), r);
                            rel_ptr++;
                            n++;
                        end
                        if (rel_ptr >= entries)
                            armed = 0;
                        if (n == 0)
                            push_status(terq_pkg::ST_OK);
                        else
                            release_q[$].last = 1'b1;
                    end
                end
            endcase
        endfunction

        // empty string when the transfer matches the oldest expectation
        function string check_result(result_t got);
            result_t e;
            string msg;
            if (release_q.size() == 0)
                return $sformatf("unexpected transfer status=%0d", got.status);
            e = release_q.pop_front();
            msg = "";
            if (got.status !== e.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
            if (got.due !== e.due)
                msg = {msg, $sformatf(" due_time %0h/%0h", got.due, e.due)};
            if (got.idx !== e.idx)
                msg = {msg, $sformatf(" load_index %0d/%0d", got.idx, e.idx)};
            if (got.unit !== e.unit)
                msg = {msg, $sformatf(" unit_out %0d/%0d", got.unit, e.unit)};
            if (got.data !== e.data)
                msg = {msg, $sformatf(" data_out %0h/%0h", got.data, e.data)};
            if (got.known !== e.known)
                msg = {msg, $sformatf(" unit_known %0b/%0b", got.known, e.known)};
            if (got.kind !== e.kind)
                msg = {msg, $sformatf(" kind_out %0h/%0h", got.kind, e.kind)};
            if (got.sound !== e.sound)
                msg = {msg, $sformatf(" sound_out %0h/%0h", got.sound, e.sound)};
            if (got.last !== e.last)
                msg = {msg, $sformatf(" last %0b/%0b", got.last, e.last)};
            if (msg != "")
                msg = {"mismatch (got/exp):", msg};
            return msg;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [7:0]  unit_kind_in;
    logic [15:0] sound_in;
    logic [31:0] delay_amount;
    logic        delay_is_frames;
    logic        delay_bad;
    logic [7:0]  target_unit;
    logic [31:0] trigger_data;
    logic [47:0] now_time;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [47:0] due_time;
    logic [4:0]  load_index;
    logic [7:0]  unit_out;
    logic [31:0] data_out;
    logic        unit_known;
    logic [7:0]  kind_out;
    logic [15:0] sound_out;
    logic        last;

    timed_event_release_queue uut (.*);

    release_scoreboard sb;
    int    fails;
    int    cycles;
    int    items_sent;
    bit    gaps_on;
    bit    stalls_on;
    int    stall_left;
    bit [47:0] clock_now;

    always #1 clk = ~clk;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fails++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LimitCycles)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver side stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (stalls_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        string msg;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status;
            got.due = due_time;
            got.idx = load_index;
            got.unit = unit_out;
            got.data = data_out;
            got.known = unit_known;
            got.kind = kind_out;
            got.sound = sound_out;
            got.last = last;
            msg = sb.check_result(got);
            if (msg != "")
                report(msg);
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        op <= it.op;
        unit_kind_in <= it.kind;
        sound_in <= it.sound;
        delay_amount <= it.amount;
        delay_is_frames <= it.frames;
        delay_bad <= it.bad;
        target_unit <= it.unit;
        trigger_data <= it.data;
        now_time <= it.now;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
        items_sent++;
        gap = (gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every expected transfer has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 3;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == terq_pkg::REG_TICK)
            sb.tick = value[15:0];
        else
            sb.start = value[47:0];
    endtask

    function automatic item_t blank_item(input logic [1:0] code);
        item_t it;
        it.op = code;
        it.kind = 8'($urandom);
        it.sound = 16'($urandom);
        it.amount = $urandom;
        it.frames = 1'($urandom);
        it.bad = 1'($urandom);
        it.unit = 8'($urandom);
        it.data = $urandom;
        it.now = {16'($urandom), 32'($urandom)};
        return it;
    endfunction

    function automatic item_t unit_item(input logic [7:0] k, input logic [15:0] s);
        item_t it;
        it = blank_item(terq_pkg::OP_UNIT);
        it.kind = k;
        it.sound = s;
        return it;
    endfunction

    function automatic item_t trig_item(input logic [31:0] amt, input logic fr,
                                        input logic bd, input logic [7:0] u,
                                        input logic [31:0] d);
        item_t it;
        it = blank_item(terq_pkg::OP_TRIGGER);
        it.amount = amt;
        it.frames = fr;
        it.bad = bd;
        it.unit = u;
        it.data = d;
        return it;
    endfunction

    function automatic item_t adv_item(input logic [47:0] t);
        item_t it;
        it = blank_item(terq_pkg::OP_ADVANCE);
        it.now = t;
        return it;
    endfunction

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = 49'(a) + 49'(b);
        return s[48] ? terq_pkg::TimeMax : s[47:0];
    endfunction

    // optional clear, units, triggers, then a run of advances and an optional unit
    task automatic schedule_run();
        int nu;
        int nt;
        int na;
        logic [31:0] amt;
        logic fr;
        if ($urandom_range(0, 9) != 0)
            send_item(blank_item(terq_pkg::OP_CLEAR));
        clock_now = sb.start;
        nu = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(0, 6);
        for (int i = 0; i < nu; i++)
            send_item(unit_item(8'($urandom), 16'($urandom)));
        nt = ($urandom_range(0, 11) == 0) ? 33 : $urandom_range(1, 8);
        for (int i = 0; i < nt; i++)
        begin
            fr = ($urandom_range(0, 3) == 0);
            amt = fr ? $urandom_range(0, 12) : $urandom_range(0, 200);
            if ($urandom_range(0, 15) == 0)
                amt = $urandom;
            send_item(trig_item(amt, fr, $urandom_range(0, 20) == 0,
                                ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, nu + 1)),
                                $urandom));
        end
        na = $urandom_range(1, 4);
        for (int i = 0; i < na; i++)
        begin
            if ($urandom_range(0, 7) == 0 && clock_now > 0)
                send_item(adv_item(clock_now - 1));
            else
            begin
                clock_now = sat_add(clock_now, 48'($urandom_range(0, 120)));
                send_item(adv_item(clock_now));
            end
        end
        if ($urandom_range(0, 2) == 0)
            send_item(adv_item(terq_pkg::TimeMax));
        if ($urandom_range(0, 6) == 0)
            send_item(unit_item(8'($urandom), 16'($urandom)));
    endtask

    task automatic random_phase(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(blank_item(2'($urandom)));
            else
                schedule_run();
        end
    endtask

    initial
    begin
        sb = new();
        sb.power_up();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = terq_pkg::OP_CLEAR;
        unit_kind_in = '0;
        sound_in = '0;
        delay_amount = '0;
        delay_is_frames = 1'b0;
        delay_bad = 1'b0;
        target_unit = '0;
        trigger_data = '0;
        now_time = '0;
        out_stall = 1'b0;
        stall_left = 0;
        fails = 0;
        cycles = 0;
        items_sent = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: inactive advance, loads, stable order, unknown units
        send_item(adv_item('0));
        send_item(trig_item(32'd1, 1'b0, 1'b0, 8'd0, 32'h1));
        send_item(blank_item(terq_pkg::OP_CLEAR));
        send_item(unit_item(8'hff, 16'hffff));
        send_item(unit_item(8'h00, 16'h0000));
        send_item(trig_item(32'd5, 1'b0, 1'b0, 8'd0, 32'hffffffff));
        send_item(trig_item(32'd5, 1'b0, 1'b0, 8'd1, 32'h0));
        send_item(trig_item(32'd3, 1'b1, 1'b0, 8'd200, 32'h5a5a5a5a));
        send_item(trig_item(32'd0, 1'b0, 1'b0, 8'hff, 32'h0));
        send_item(adv_item(48'd2));
        send_item(adv_item(48'd1));
        send_item(adv_item(48'd100));
        send_item(unit_item(8'h12, 16'h3456));
        send_item(blank_item(terq_pkg::OP_CLEAR));
        send_item(trig_item(32'd7, 1'b0, 1'b1, 8'd0, 32'h0));
        send_item(blank_item(terq_pkg::OP_CLEAR));
        send_item(trig_item(32'hffffffff, 1'b1, 1'b0, 8'd0, 32'h1));
        send_item(trig_item(32'hffffffff, 1'b0, 1'b0, 8'd0, 32'h2));
        send_item(adv_item(terq_pkg::TimeMax));
        wait_drained();

        apb_write(terq_pkg::REG_TICK, 64'd0);
        apb_write(terq_pkg::REG_START, {16'd0, terq_pkg::TimeMax});
        send_item(blank_item(terq_pkg::OP_CLEAR));
        send_item(trig_item(32'd1, 1'b1, 1'b0, 8'd0, 32'h3));
        send_item(blank_item(terq_pkg::OP_CLEAR));
        send_item(trig_item(32'd1, 1'b0, 1'b0, 8'd0, 32'h4));
        send_item(adv_item(terq_pkg::TimeMax));
        wait_drained();

        apb_write(terq_pkg::REG_TICK, 64'hffff);
        apb_write(terq_pkg::REG_START, 64'd0);
        random_phase(100);
        wait_drained();

        apb_write(terq_pkg::REG_TICK, 64'd1);
        apb_write(terq_pkg::REG_START, 64'($urandom_range(0, 100000)));
        stalls_on = 1'b0;
        random_phase(100);
        wait_drained();

        apb_write(terq_pkg::REG_TICK, 64'($urandom_range(1, 65535)));
        apb_write(terq_pkg::REG_START, {16'($urandom), 32'($urandom)});
        stalls_on = 1'b1;
        gaps_on = 1'b0;
        random_phase(60);
        wait_drained();

        apb_write(terq_pkg::REG_TICK, 64'(terq_pkg::TickReset));
        apb_write(terq_pkg::REG_START, 64'($urandom_range(0, 1000)));
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_phase(100);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
